// ===== rtl/core/qau_pkg.sv =====
// Shared types and constants for the quaternion arithmetic unit.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_ROT   = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_CONJ  = 3'd4,
    OP_SCALE = 3'd5
  } op_t;

  // Control for one two-stage Hamilton product slice.
  typedef struct packed {
    logic prod_en;
    logic sum_en;
    logic term0_only;
  } ham_ctl_t;

  // Subtracted terms of the Hamilton product, bit (component * 4 + term).
  // Term k of component c uses p[c ^ k] * q[k].
  localparam logic [15:0] HAM_NEG = 16'b0010_1000_0100_1110;

endpackage

`default_nettype wire

// ===== rtl/core/qau_hamilton.sv =====
// Two-stage Hamilton product: rounded partial products, then signed sums
// with saturation. Depends on qau_pkg for ham_ctl_t and HAM_NEG.
`timescale 1ns / 1ps
`default_nettype none

module qau_hamilton
  import qau_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                       clk,
  input  wire ham_ctl_t                   ctl_i,
  input  wire logic [3:0][DATA_WIDTH-1:0] p_i,
  input  wire logic [3:0][DATA_WIDTH-1:0] q_i,
  output logic      [3:0][DATA_WIDTH-1:0] r_o
);

  localparam int MW = 2 * DATA_WIDTH;
  localparam int PW = MW + 1;
  localparam int SW = PW + 2;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [MW-1:0] mp       [4][4];
  logic signed [PW-1:0] rnd_nxt  [4][4];
  logic signed [PW-1:0] rnd_r    [4][4];
  logic                 t0_r;
  logic [3:0][DATA_WIDTH-1:0] sum_nxt;
  logic [3:0][DATA_WIDTH-1:0] sum_r;

  function automatic logic [DATA_WIDTH-1:0] sat_sum(input logic signed [SW-1:0] v);
    logic [DATA_WIDTH-1:0] res;
    if (v[SW-1:DATA_WIDTH-1] == {(SW-DATA_WIDTH+1){v[SW-1]}}) begin
      res = v[DATA_WIDTH-1:0];
    end else if (v[SW-1]) begin
      res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        mp[c][k] = MW'($signed(p_i[2'(c ^ k)])) * MW'($signed(q_i[2'(k)]));
        rnd_nxt[c][k] = ($signed({mp[c][k][MW-1], mp[c][k]}) + RND_HALF) >>> FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.prod_en) begin
      rnd_r <= rnd_nxt;
      t0_r  <= ctl_i.term0_only;
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] ext;
    for (int c = 0; c < 4; c++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        ext = $signed({{2{rnd_r[c][k][PW-1]}}, rnd_r[c][k]});
        if (t0_r && k != 0) begin
          ext = '0;
        end
        if (HAM_NEG[4'(c * 4 + k)]) begin
          acc = acc - ext;
        end else begin
          acc = acc + ext;
        end
      end
      sum_nxt[c] = sat_sum(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign r_o = sum_r;

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_arith_unit_top.sv =====
// Top level of the quaternion arithmetic unit: input register, two chained
// Hamilton product slices, add/sub/conjugate path and output register.
// Depends on qau_pkg and qau_hamilton.
//
// Usage: present an item on in_* with in_valid high; it is taken at a rising
// edge where in_valid is high and in_stall is low. Each item carries an
// opcode and quaternions A and B in signed fixed point and yields exactly one
// result quaternion on out_r_*, marked by out_valid and taken when out_stall
// is low. Results leave in the order items arrive.
// Pipeline: six register stages, s0 to s4 and then the output register.
// Throughput: one item per cycle while out_stall is low, set by the fully
// pipelined multiplier slices (16 multipliers per slice).
// Rotation runs the second slice on the first slice's result, so every
// opcode walks the same six stages.
// Reset clears all stage valid bits; the pipeline is empty afterwards.
// When the receiver stalls, a stage that holds an item keeps it unless a later
// stage is empty; in_stall rises only when every stage is full, and no item is
// lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arith_unit_top
  import qau_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic        [2:0]            in_opcode,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_s,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_z,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_s,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_r_s,
  output logic signed [DATA_WIDTH-1:0]      out_r_x,
  output logic signed [DATA_WIDTH-1:0]      out_r_y,
  output logic signed [DATA_WIDTH-1:0]      out_r_z
);

  localparam int W = DATA_WIDTH;

  typedef logic [3:0][W-1:0] quat_t;

  logic  en0, en1, en2, en3, en4, en5;
  logic  s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;

  op_t   s0_op_r, s1_op_r, s2_op_r, s3_op_r, s4_op_r;
  quat_t s0_a_r, s0_b_r, s1_a_r, s2_a_r;
  quat_t simp_nxt, s1_simp_r, s2_simp_r, s3_simp_r, s4_simp_r;
  quat_t s3_h1_r, s4_h1_r;
  quat_t ham1_q, ham1_r, conj_a, ham2_r;
  quat_t out_nxt, out_q_r;
  ham_ctl_t ham1_ctl, ham2_ctl;

  function automatic logic [W-1:0] sat1(input logic signed [W:0] v);
    logic [W-1:0] res;
    if (v[W] == v[W-1]) begin
      res = v[W-1:0];
    end else if (v[W]) begin
      res = {1'b1, {(W-1){1'b0}}};
    end else begin
      res = {1'b0, {(W-1){1'b1}}};
    end
    return res;
  endfunction

  // Stall chain: a stage advances when empty or when the next one advances.
  assign en5      = !out_v_r || !out_stall;
  assign en4      = !s4_v_r || en5;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign en0      = !s0_v_r || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en0) s0_v_r  <= in_valid;
      if (en1) s1_v_r  <= s0_v_r;
      if (en2) s2_v_r  <= s1_v_r;
      if (en3) s3_v_r  <= s2_v_r;
      if (en4) s4_v_r  <= s3_v_r;
      if (en5) out_v_r <= s4_v_r;
    end
  end

  // Stage 0: capture the item.
  always_ff @(posedge clk) begin
    if (en0) begin
      s0_op_r <= op_t'(in_opcode);
      s0_a_r  <= {in_a_z, in_a_y, in_a_x, in_a_s};
      s0_b_r  <= {in_b_z, in_b_y, in_b_x, in_b_s};
    end
  end

  always_comb begin
    simp_nxt = '0;
    case (s0_op_r)
      OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          simp_nxt[i] = sat1($signed({s0_a_r[i][W-1], s0_a_r[i]}) +
                             $signed({s0_b_r[i][W-1], s0_b_r[i]}));
        end
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          simp_nxt[i] = sat1($signed({s0_a_r[i][W-1], s0_a_r[i]}) -
                             $signed({s0_b_r[i][W-1], s0_b_r[i]}));
        end
      end
      OP_CONJ: begin
        simp_nxt[0] = s0_a_r[0];
        for (int i = 1; i < 4; i++) begin
          simp_nxt[i] = sat1(-$signed({s0_a_r[i][W-1], s0_a_r[i]}));
        end
      end
      default: simp_nxt = '0;
    endcase
  end

  // First slice: A*B, A*(0,v) for rotation, or A times b_s for scale.
  always_comb begin
    ham1_q = s0_b_r;
    if (s0_op_r == OP_ROT) begin
      ham1_q[0] = '0;
    end
  end

  assign ham1_ctl = '{prod_en: en1, sum_en: en2, term0_only: (s0_op_r == OP_SCALE)};

  qau_hamilton #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ham1 (
    .clk   (clk),
    .ctl_i (ham1_ctl),
    .p_i   (s0_a_r),
    .q_i   (ham1_q),
    .r_o   (ham1_r)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r   <= s0_op_r;
      s1_a_r    <= s0_a_r;
      s1_simp_r <= simp_nxt;
    end
    if (en2) begin
      s2_op_r   <= s1_op_r;
      s2_a_r    <= s1_a_r;
      s2_simp_r <= s1_simp_r;
    end
    if (en3) begin
      s3_op_r   <= s2_op_r;
      s3_simp_r <= s2_simp_r;
      s3_h1_r   <= ham1_r;
    end
    if (en4) begin
      s4_op_r   <= s3_op_r;
      s4_simp_r <= s3_simp_r;
      s4_h1_r   <= s3_h1_r;
    end
  end

  // Second slice: T * conj(A) for rotation.
  always_comb begin
    conj_a[0] = s2_a_r[0];
    for (int i = 1; i < 4; i++) begin
      conj_a[i] = sat1(-$signed({s2_a_r[i][W-1], s2_a_r[i]}));
    end
  end

  assign ham2_ctl = '{prod_en: en3, sum_en: en4, term0_only: 1'b0};

  qau_hamilton #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ham2 (
    .clk   (clk),
    .ctl_i (ham2_ctl),
    .p_i   (ham1_r),
    .q_i   (conj_a),
    .r_o   (ham2_r)
  );

  always_comb begin
    out_nxt = '0;
    case (s4_op_r)
      OP_MUL, OP_SCALE: out_nxt = s4_h1_r;
      OP_ROT: begin
        out_nxt    = ham2_r;
        out_nxt[0] = '0;
      end
      OP_ADD, OP_SUB, OP_CONJ: out_nxt = s4_simp_r;
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_q_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_r_s   = out_q_r[0];
  assign out_r_x   = out_q_r[1];
  assign out_r_y   = out_q_r[2];
  assign out_r_z   = out_q_r[3];

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_v_r && s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_v_r))
    else $error("input stalled while a stage is empty");

  a_item_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en5 && s4_v_r) |=> out_v_r)
    else $error("item dropped at output register");

  a_rot_real_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en5 && s4_v_r && s4_op_r == OP_ROT) |=> (out_r_s == '0))
    else $error("rotation result has nonzero real part");

  a_unused_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en5 && s4_v_r && s4_op_r > OP_SCALE) |=> (out_q_r == '0))
    else $error("unused opcode gave nonzero result");

endmodule

`default_nettype wire

// ===== tb/quaternion_arith_unit_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_arith_unit_top: directed corner items, then random
// items under three idling mixes, each result checked against an in-bench fixed-point model.
// Depends on qau_pkg and the quaternion_arith_unit_top RTL.

module quaternion_arith_unit_top_tb;
  import qau_pkg::*;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam longint CMAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint CMIN = -(longint'(1) <<< (DW - 1));
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 435;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef logic signed [DW-1:0] comp_t;
  typedef struct packed {
    comp_t s;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  class quat_tracker;
    quat_t awaited_quats[$];
    int mismatches;
    int results_seen;
    int op_items[8];

    function new();
      mismatches = 0;
      results_seen = 0;
      foreach (op_items[i]) op_items[i] = 0;
    endfunction

    function comp_t clamp(longint v);
      if (v > CMAX) return comp_t'(CMAX);
      if (v < CMIN) return comp_t'(CMIN);
      return comp_t'(v);
    endfunction

    // round to nearest, ties toward plus infinity
    function longint rprod(longint p, longint q);
      return (p * q + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function quat_t hamilton(quat_t p, quat_t q);
      quat_t r;
      r.s = clamp(rprod(p.s, q.s) - rprod(p.x, q.x) - rprod(p.y, q.y) - rprod(p.z, q.z));
      r.x = clamp(rprod(p.x, q.s) + rprod(p.s, q.x) - rprod(p.z, q.y) + rprod(p.y, q.z));
      r.y = clamp(rprod(p.y, q.s) + rprod(p.z, q.x) + rprod(p.s, q.y) - rprod(p.x, q.z));
      r.z = clamp(rprod(p.z, q.s) - rprod(p.y, q.x) + rprod(p.x, q.y) + rprod(p.s, q.z));
      return r;
    endfunction

    function quat_t conj(quat_t p);
      quat_t r;
      r.s = p.s;
      r.x = clamp(-longint'(p.x));
      r.y = clamp(-longint'(p.y));
      r.z = clamp(-longint'(p.z));
      return r;
    endfunction

    function quat_t compute_quat(logic [2:0] op, quat_t a, quat_t b);
      quat_t r;
      quat_t t;
      quat_t v;
      r = '0;
      case (op)
        OP_MUL: r = hamilton(a, b);
        OP_ROT: begin
          v = b;
          v.s = '0;
          t = hamilton(a, v);
          r = hamilton(t, conj(a));
          r.s = '0;
        end
        OP_ADD: begin
          r.s = clamp(longint'(a.s) + longint'(b.s));
          r.x = clamp(longint'(a.x) + longint'(b.x));
          r.y = clamp(longint'(a.y) + longint'(b.y));
          r.z = clamp(longint'(a.z) + longint'(b.z));
        end
        OP_SUB: begin
          r.s = clamp(longint'(a.s) - longint'(b.s));
          r.x = clamp(longint'(a.x) - longint'(b.x));
          r.y = clamp(longint'(a.y) - longint'(b.y));
          r.z = clamp(longint'(a.z) - longint'(b.z));
        end
        OP_CONJ: r = conj(a);
        OP_SCALE: begin
          r.s = clamp(rprod(a.s, b.s));
          r.x = clamp(rprod(a.x, b.s));
          r.y = clamp(rprod(a.y, b.s));
          r.z = clamp(rprod(a.z, b.s));
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_item(logic [2:0] op, quat_t a, quat_t b);
      op_items[op]++;
      awaited_quats.push_back(compute_quat(op, a, b));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(quat_t got);
      string names[4];
      quat_t want;
      comp_t gc;
      comp_t wc;
      names = '{"r_s", "r_x", "r_y", "r_z"};
      results_seen++;
      if (awaited_quats.size() == 0) begin
        report_mismatch($sformatf("result %0d (%h) with no item outstanding",
                                  results_seen, got));
        return;
      end
      want = awaited_quats.pop_front();
      for (int i = 0; i < 4; i++) begin
        gc = got[4*DW-1 - DW*i -: DW];
        wc = want[4*DW-1 - DW*i -: DW];
        if (gc !== wc)
          report_mismatch($sformatf("result %0d: %s is %0d, want %0d",
                                    results_seen, names[i], gc, wc));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = OP_MUL;
  comp_t in_a_s = '0;
  comp_t in_a_x = '0;
  comp_t in_a_y = '0;
  comp_t in_a_z = '0;
  comp_t in_b_s = '0;
  comp_t in_b_x = '0;
  comp_t in_b_y = '0;
  comp_t in_b_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  comp_t out_r_s;
  comp_t out_r_x;
  comp_t out_r_y;
  comp_t out_r_z;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  quat_tracker tracker = new();

  quaternion_arith_unit_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_a_s(in_a_s),
    .in_a_x(in_a_x),
    .in_a_y(in_a_y),
    .in_a_z(in_a_z),
    .in_b_s(in_b_s),
    .in_b_x(in_b_x),
    .in_b_y(in_b_y),
    .in_b_z(in_b_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_r_s(out_r_s),
    .out_r_x(out_r_x),
    .out_r_y(out_r_y),
    .out_r_z(out_r_z)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      tracker.note_item(in_opcode, {in_a_s, in_a_x, in_a_y, in_a_z},
                        {in_b_s, in_b_x, in_b_y, in_b_z});
    if (rst_n && out_valid && !out_stall)
      tracker.check_result({out_r_s, out_r_x, out_r_y, out_r_z});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL quaternion_arith_unit_top");
      $finish;
    end
  end

  function automatic quat_t quat_of(int s, int x, int y, int z);
    return {comp_t'(s), comp_t'(x), comp_t'(y), comp_t'(z)};
  endfunction

  function automatic comp_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: return comp_t'(CMAX);
          1: return comp_t'(CMIN);
          2: return comp_t'(0);
          3: return comp_t'(16384);
          4: return comp_t'(-16384);
          5: return comp_t'(1);
          default: return comp_t'(-1);
        endcase
      end
      1, 2, 3: return comp_t'(int'($urandom_range(0, 32768)) - 16384);
      default: return comp_t'($urandom());
    endcase
  endfunction

  function automatic quat_t random_quat();
    return {pick_value(), pick_value(), pick_value(), pick_value()};
  endfunction

  task automatic send_item(logic [2:0] op, quat_t a, quat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    {in_a_s, in_a_x, in_a_y, in_a_z} <= a;
    {in_b_s, in_b_x, in_b_y, in_b_z} <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      op = 3'($urandom_range(OP_MUL, OP_SCALE));
      send_item(op, random_quat(), random_quat());
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited_quats.size() != 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 33;
    recv_idle_pct = 52;

    send_item(OP_MUL, quat_of(32767, 32767, 32767, 32767), quat_of(32767, 32767, 32767, 32767));
    send_item(OP_MUL, quat_of(-32768, -32768, -32768, -32768),
              quat_of(-32768, -32768, -32768, -32768));
    send_item(OP_MUL, quat_of(32767, -32768, 32767, -32768),
              quat_of(-32768, 32767, -32768, 32767));
    send_item(OP_MUL, quat_of(16384, 0, 0, 0), quat_of(1234, -5678, 9012, -3456));
    send_item(OP_MUL, quat_of(1, -1, 1, -1), quat_of(8192, 8192, -8192, 8192));
    send_item(OP_ROT, quat_of(11585, 0, 0, 11585), quat_of(-32768, 16384, 0, 0));
    send_item(OP_ROT, quat_of(-32768, -32768, -32768, -32768),
              quat_of(32767, 32767, -32768, 32767));
    send_item(OP_ROT, quat_of(32767, 32767, 32767, 32767), quat_of(0, 32767, 32767, 32767));
    send_item(OP_ADD, quat_of(32767, 32767, 32767, 32767), quat_of(32767, 32767, 32767, 32767));
    send_item(OP_ADD, quat_of(32767, -32768, 32767, -32768), quat_of(32767, -32768, 1, -1));
    send_item(OP_ADD, quat_of(0, 0, 0, 0), quat_of(0, 0, 0, 0));
    send_item(OP_SUB, quat_of(-32768, 32767, 0, -1), quat_of(32767, -32768, 0, 32767));
    send_item(OP_CONJ, quat_of(-32768, -32768, -32768, -32768), quat_of(1, 2, 3, 4));
    send_item(OP_CONJ, quat_of(32767, 32767, 0, -1), quat_of(-1, -1, -1, -1));
    send_item(OP_SCALE, quat_of(-32768, 32767, 1, -1), quat_of(-32768, 5, 6, 7));
    send_item(OP_SCALE, quat_of(1, -1, 8192, -8192), quat_of(8192, 0, 0, 0));
    send_item(OP_SCALE, quat_of(32767, -32768, 0, 16384), quat_of(32767, -1, -1, -1));
    send_item(OP_SPARE6, quat_of(100, -200, 300, -400), quat_of(5, 6, 7, 8));
    send_item(OP_SPARE7, quat_of(-32768, 32767, -1, 1), quat_of(32767, -32768, 1, -1));
    drain();

    send_random(RANDOM_PER_PHASE);
    send_idle_pct = 52;
    recv_idle_pct = 33;
    send_random(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d mul, %0d rotate, %0d add, %0d sub, %0d conj, %0d scale",
             tracker.results_seen, tracker.op_items[OP_MUL], tracker.op_items[OP_ROT],
             tracker.op_items[OP_ADD], tracker.op_items[OP_SUB], tracker.op_items[OP_CONJ],
             tracker.op_items[OP_SCALE]);
    $display("Spare opcodes %0d; idling mixes 33/52, 52/33 and none; %0d mismatches",
             tracker.op_items[OP_SPARE6] + tracker.op_items[OP_SPARE7], tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("PASS quaternion_arith_unit_top");
    else
      $display("FAIL quaternion_arith_unit_top");
    $finish;
  end

endmodule
